// ===== rtl/mdio22_pkg.sv =====
// ----------------------------------------------------------------------------
// MDIO clause-22 master package
// Shared types, register offsets and frame constants.
// ----------------------------------------------------------------------------
package mdio22_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int POS_W         = 7;
  localparam int DIV_W         = 10;
  localparam int CMD_W         = 15;

  localparam logic [POS_W-1:0] HEAD_POS  = POS_W'(PREAMBLE_BITS + 14);
  localparam logic [POS_W-1:0] FRAME_POS = POS_W'(PREAMBLE_BITS + 32);
  localparam logic [POS_W-1:0] PRE_POS   = POS_W'(PREAMBLE_BITS);

  localparam logic [9:0] OFS_COMMAND = 10'h000;
  localparam logic [9:0] OFS_WDATA   = 10'h008;
  localparam logic [9:0] OFS_RDATA   = 10'h00c;
  localparam logic [9:0] OFS_STATUS  = 10'h010;

  localparam int CMD_START = 14;
  localparam int CMD_READ  = 11;
  localparam int CMD_WRITE = 10;

  localparam logic [DIV_W-1:0] HALF_RESET = DIV_W'(25);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_kind_e;

  typedef enum logic [2:0] {
    SEL_NONE    = 3'd0,
    SEL_COMMAND = 3'd1,
    SEL_WDATA   = 3'd2,
    SEL_RDATA   = 3'd3,
    SEL_STATUS  = 3'd4
  } reg_sel_e;

  typedef struct packed {
    req_kind_e   kind;
    reg_sel_e    sel;
    logic [31:0] wdata;
    logic        mdio_in;
  } req_t;

  typedef struct packed {
    logic [31:0] bus_rdata;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy;
  } res_t;

endpackage

// ===== rtl/mdio_clause22_master_top.sv =====
// ----------------------------------------------------------------------------
// MDIO clause-22 management master
// Register-mapped master that sends clause-22 frames on MDC/MDIO.
//
//   channel      dir  handshake                      payload
//   s_axis       in   s_axis_tvalid_i/tready_o       tuser req_type, tdata request
//   m_axis       out  m_axis_tvalid_o/tready_i       tdata result
//   cfg          in   cfg_valid_i/cfg_ready_o        cfg_data_i MDC half period
//
// One request per cycle while the output is not stalled; a result passes
// through a queue slot and then the result register in the engine.
// Reset clears control state, not queue slots or result data; no clearing pass is needed.
// A stalled output holds the engine; the two-entry queue takes up to two more
// requests before the input drops ready. The config port is always ready.
// ----------------------------------------------------------------------------
module mdio_clause22_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  input  logic [47:0] s_axis_tdata_i,   // [9:0] reg_offset, [41:10] bus_wdata, [42] mdio_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] bus_rdata, [32] mdc, [33] mdio_out,
                                        // [34] mdio_drive, [35] busy_res
);

  logic [9:0]       half_q;
  logic             q_valid;
  logic             q_pop;
  mdio22_pkg::req_t q_req;
  mdio22_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= mdio22_pkg::HALF_RESET;
    end else if (cfg_valid_i) begin
      half_q <= cfg_data_i;
    end
  end

  mdio22_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_type_i   (s_axis_tuser_i),
    .reg_offset_i (s_axis_tdata_i[9:0]),
    .bus_wdata_i  (s_axis_tdata_i[41:10]),
    .mdio_in_i    (s_axis_tdata_i[42]),
    .q_valid_o    (q_valid),
    .q_req_o      (q_req),
    .q_pop_i      (q_pop)
  );

  mdio22_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_q),
    .q_valid_i     (q_valid),
    .q_req_i       (q_req),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_res_o     (res)
  );

  assign m_axis_tdata_o = {4'd0, res.busy, res.mdio_drive, res.mdio_out, res.mdc,
                           res.bus_rdata};

endmodule

// ===== rtl/mdio22_front.sv =====
// ----------------------------------------------------------------------------
// MDIO clause-22 master front end
// Accepts bus requests, decodes kind and register, holds them in a
// two-entry queue for the frame engine.
// ----------------------------------------------------------------------------
module mdio22_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [9:0]        reg_offset_i,
  input  logic [31:0]       bus_wdata_i,
  input  logic              mdio_in_i,
  output logic              q_valid_o,
  output mdio22_pkg::req_t  q_req_o,
  input  logic              q_pop_i
);

  mdio22_pkg::req_t slot_q [2];
  mdio22_pkg::req_t req_dec;
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             push;

  always_comb begin
    req_dec.wdata   = bus_wdata_i;
    req_dec.mdio_in = mdio_in_i;
    case (req_type_i)
      mdio22_pkg::REQ_READ:  req_dec.kind = mdio22_pkg::REQ_READ;
      mdio22_pkg::REQ_WRITE: req_dec.kind = mdio22_pkg::REQ_WRITE;
      default:               req_dec.kind = mdio22_pkg::REQ_TICK;
    endcase
    case (reg_offset_i)
      mdio22_pkg::OFS_COMMAND: req_dec.sel = mdio22_pkg::SEL_COMMAND;
      mdio22_pkg::OFS_WDATA:   req_dec.sel = mdio22_pkg::SEL_WDATA;
      mdio22_pkg::OFS_RDATA:   req_dec.sel = mdio22_pkg::SEL_RDATA;
      mdio22_pkg::OFS_STATUS:  req_dec.sel = mdio22_pkg::SEL_STATUS;
      default:                 req_dec.sel = mdio22_pkg::SEL_NONE;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_req_o    = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_dec;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/mdio22_back.sv =====
// ----------------------------------------------------------------------------
// MDIO clause-22 master frame engine
// Applies register reads, and writes while no frame runs, runs the MDC
// divider and frame sequencer, and registers one result per request.
// ----------------------------------------------------------------------------
module mdio22_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [9:0]             half_period_i,
  input  logic                   q_valid_i,
  input  mdio22_pkg::req_t       q_req_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mdio22_pkg::res_t       out_res_o
);

  logic [mdio22_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [15:0]                   wr_q, wr_d;
  logic [15:0]                   rd_q, rd_d;
  logic                          fail_q, fail_d;
  logic [mdio22_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [mdio22_pkg::DIV_W-1:0]  div_q, div_d;
  logic                          lvl_q, lvl_d;
  logic                          out_valid_q;
  mdio22_pkg::res_t              res_q, res_d;
  logic                          take;

  always_comb begin
    logic [mdio22_pkg::DIV_W-1:0] half;
    logic [mdio22_pkg::DIV_W:0]   nxt;
    logic [mdio22_pkg::POS_W-1:0] j;
    logic [31:0]                  tail;
    logic                         rd_frame;
    logic                         busy;
    cmd_d  = cmd_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    fail_d = fail_q;
    pos_d  = pos_q;
    div_d  = div_q;
    lvl_d  = lvl_q;
    res_d  = '0;
    busy   = cmd_q[mdio22_pkg::CMD_START];

    if (q_req_i.kind == mdio22_pkg::REQ_READ) begin
      case (q_req_i.sel)
        mdio22_pkg::SEL_COMMAND: res_d.bus_rdata = {17'd0, cmd_q};
        mdio22_pkg::SEL_WDATA:   res_d.bus_rdata = {16'd0, wr_q};
        mdio22_pkg::SEL_RDATA:   res_d.bus_rdata = {16'd0, rd_q};
        mdio22_pkg::SEL_STATUS:  res_d.bus_rdata = {31'd0, fail_q};
        default:                 res_d.bus_rdata = '0;
      endcase
    end else if (q_req_i.kind == mdio22_pkg::REQ_WRITE && !busy) begin
      if (q_req_i.sel == mdio22_pkg::SEL_COMMAND) begin
        cmd_d = q_req_i.wdata[mdio22_pkg::CMD_W-1:0];
        if (!cmd_d[mdio22_pkg::CMD_READ] && !cmd_d[mdio22_pkg::CMD_WRITE]) begin
          cmd_d[mdio22_pkg::CMD_START] = 1'b0;
        end
        if (cmd_d[mdio22_pkg::CMD_START]) begin
          pos_d = '0;
          div_d = '0;
          lvl_d = 1'b0;
        end
      end else if (q_req_i.sel == mdio22_pkg::SEL_WDATA) begin
        wr_d = q_req_i.wdata[15:0];
      end
    end

    rd_frame = cmd_d[mdio22_pkg::CMD_READ];
    half     = (half_period_i == '0) ? mdio22_pkg::DIV_W'(1) : half_period_i;
    nxt      = {1'b0, div_d} + 11'd1;

    if (cmd_d[mdio22_pkg::CMD_START]) begin
      if (nxt < {1'b0, half}) begin
        div_d = nxt[mdio22_pkg::DIV_W-1:0];
      end else begin
        div_d = '0;
        if (!lvl_d) begin
          lvl_d = 1'b1;
          if (rd_frame && pos_d >= mdio22_pkg::HEAD_POS + 7'd1) begin
            if (pos_d == mdio22_pkg::HEAD_POS + 7'd1) begin
              fail_d = q_req_i.mdio_in;
            end else if (pos_d < mdio22_pkg::FRAME_POS) begin
              rd_d = {rd_d[14:0], q_req_i.mdio_in};
            end
          end
        end else begin
          lvl_d = 1'b0;
          pos_d = pos_d + 7'd1;
          if (pos_d >= mdio22_pkg::FRAME_POS) begin
            pos_d = '0;
            cmd_d[mdio22_pkg::CMD_START] = 1'b0;
          end
        end
      end
    end

    tail = {2'b01, (rd_frame ? 2'b10 : 2'b01), cmd_d[9:5], cmd_d[4:0], 2'b10, wr_d};
    j    = pos_d - mdio22_pkg::PRE_POS;
    res_d.busy       = cmd_d[mdio22_pkg::CMD_START];
    res_d.mdc        = lvl_d;
    res_d.mdio_drive = res_d.busy && !(rd_frame && pos_d >= mdio22_pkg::HEAD_POS);
    if (!res_d.mdio_drive) begin
      res_d.mdio_out = 1'b0;
    end else if (pos_d < mdio22_pkg::PRE_POS) begin
      res_d.mdio_out = 1'b1;
    end else if (j < 7'd32) begin
      res_d.mdio_out = tail[~j[4:0]];
    end else begin
      res_d.mdio_out = 1'b0;
    end
  end

  assign take        = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      fail_q      <= 1'b0;
      pos_q       <= '0;
      div_q       <= '0;
      lvl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cmd_q  <= cmd_d;
        wr_q   <= wr_d;
        rd_q   <= rd_d;
        fail_q <= fail_d;
        pos_q  <= pos_d;
        div_q  <= div_d;
        lvl_q  <= lvl_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_q[mdio22_pkg::CMD_START] |-> pos_q == '0 && !lvl_q)
    else $error("sequencer not parked while idle");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < mdio22_pkg::FRAME_POS) else $error("bit position past frame end");
  a_idle_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.busy) |-> (!res_q.mdio_drive && !res_q.mdio_out && !res_q.mdc))
    else $error("MDIO driven while idle");
  a_start_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q[mdio22_pkg::CMD_START]
      |-> (cmd_q[mdio22_pkg::CMD_READ] || cmd_q[mdio22_pkg::CMD_WRITE]))
    else $error("frame running without operation");
`endif

endmodule
